### rtl/core/lcec_pkg.sv
// ---------------------------------------------------------------------------
// lcec_pkg: shared types and constants of the curvature edge classifier
// Point record, engine status and configuration register indexes.
// ---------------------------------------------------------------------------
package lcec_pkg;

   localparam int COORD_W   = 32;
   localparam int RING_W    = 6;
   localparam int MAG_W     = 33;
   localparam int PROD_W    = 66;
   localparam int WIDE_W    = 68;
   localparam int RANGE_W   = 33;
   localparam int ANGLE_W   = 34;
   localparam int JUMP_W    = 24;
   localparam int LIMIT_W   = 32;
   localparam int CSR_IDX_W = 3;

   localparam logic [ANGLE_W-1:0] ANGLE_MAX        = '1;
   localparam logic [LIMIT_W-1:0] FLAT_LIMIT_RESET = 32'd858993459;
   localparam logic [JUMP_W-1:0]  JUMP_RESET       = 24'd131072;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SENSOR_X   = 3'd0,
      CSR_SENSOR_Y   = 3'd1,
      CSR_SENSOR_Z   = 3'd2,
      CSR_FLAT_LIMIT = 3'd3,
      CSR_JUMP       = 3'd4
   } csr_idx_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      logic signed [COORD_W-1:0] z;
      logic [RING_W-1:0]         ring;
   } point_type;

   typedef struct packed {
      logic done;
      logic edge_next;
      logic edge_prev;
   } eng_stat_type;

endpackage

### rtl/core/lcec_cell.sv
// ---------------------------------------------------------------------------
// lcec_cell: one window position
// Holds one point, shifts it to its neighbor on a new beat, and adds its
// weighted coordinates to the running curvature sum passed along the row.
// ---------------------------------------------------------------------------
module lcec_cell #(
   parameter int SUM_W         = 38,
   parameter bit CENTER        = 1'b0,
   parameter int CENTER_WEIGHT = 10
) (
   input  logic                        clock,
   input  logic                        shift_en,
   input  lcec_pkg::point_type         d_in,
   output lcec_pkg::point_type         q_out,
   input  logic signed [SUM_W-1:0]     sx_in,
   input  logic signed [SUM_W-1:0]     sy_in,
   input  logic signed [SUM_W-1:0]     sz_in,
   output logic signed [SUM_W-1:0]     sx_out,
   output logic signed [SUM_W-1:0]     sy_out,
   output logic signed [SUM_W-1:0]     sz_out
);
   import lcec_pkg::*;

   point_type               pt_ff, pt_in;
   logic signed [SUM_W-1:0] sx_ff, sx_in_nx, sy_ff, sy_in_nx, sz_ff, sz_in_nx;

   // The center point counts with minus the neighbor count as its weight,
   // every other point with one.
   function automatic logic signed [SUM_W-1:0] weigh(input logic signed [COORD_W-1:0] v);
      logic signed [SUM_W-1:0] e;
      e = SUM_W'(v);
      if (CENTER)
         return -(e * SUM_W'(CENTER_WEIGHT));
      else
         return e;
   endfunction

   always_comb begin
      pt_in    = shift_en ? d_in : pt_ff;
      sx_in_nx = sx_in + weigh(pt_ff.x);
      sy_in_nx = sy_in + weigh(pt_ff.y);
      sz_in_nx = sz_in + weigh(pt_ff.z);
   end

   always_ff @(posedge clock) begin
      pt_ff <= pt_in;
      sx_ff <= sx_in_nx;
      sy_ff <= sy_in_nx;
      sz_ff <= sz_in_nx;
   end

   assign q_out  = pt_ff;
   assign sx_out = sx_ff;
   assign sy_out = sy_ff;
   assign sz_out = sz_ff;

endmodule

### rtl/core/lcec_engine.sv
// ---------------------------------------------------------------------------
// lcec_engine: range and angle unit
// Shared 33x33 multiplier, bit-pair square root and restoring divider that
// give the three ranges, two angle increments and the edge flags.
// ---------------------------------------------------------------------------
module lcec_engine (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  lcec_pkg::point_type                pa,
   input  lcec_pkg::point_type                pb,
   input  lcec_pkg::point_type                pc,
   input  logic signed [lcec_pkg::COORD_W-1:0] sensor_x,
   input  logic signed [lcec_pkg::COORD_W-1:0] sensor_y,
   input  logic signed [lcec_pkg::COORD_W-1:0] sensor_z,
   input  logic [lcec_pkg::JUMP_W-1:0]        jump,
   output lcec_pkg::eng_stat_type             stat
);
   import lcec_pkg::*;

   typedef enum logic [3:0] {
      E_IDLE, E_SQ, E_SQRT, E_DOT, E_PREP1, E_PREP2, E_PREP3, E_DIV, E_FLAGS
   } eng_state_type;

   function automatic logic [PROD_W-1:0] mul33(input logic [MAG_W-1:0] a,
                                               input logic [MAG_W-1:0] b);
      logic [63:0] lo;
      logic [32:0] cr;
      lo = a[31:0] * b[31:0];
      cr = {1'b0, (b[32] ? a[31:0] : 32'd0)} + {1'b0, (a[32] ? b[31:0] : 32'd0)};
      return {2'b00, lo} + {1'b0, cr, 32'd0} + {1'b0, a[32] & b[32], 64'd0};
   endfunction

   function automatic logic [MAG_W:0] offset(input logic signed [COORD_W-1:0] v,
                                             input logic signed [COORD_W-1:0] s);
      logic signed [MAG_W-1:0] d;
      logic signed [MAG_W-1:0] nd;
      d  = MAG_W'(v) - MAG_W'(s);
      nd = -d;
      return {d[MAG_W-1], (d[MAG_W-1] ? $unsigned(nd) : $unsigned(d))};
   endfunction

   eng_state_type           state_ff, state_in;
   logic [1:0]              j_ff, j_in;
   logic [5:0]              stp_ff, stp_in;
   logic [MAG_W-1:0]        mag_ff [3][3];
   logic [MAG_W-1:0]        mag_in [3][3];
   logic                    sgn_ff [3][3];
   logic                    sgn_in [3][3];
   logic [PROD_W-1:0]       prod_ff, prod_in;
   logic [WIDE_W-1:0]       acc_ff, acc_in, nacc_ff, nacc_in, num_ff, num_in;
   logic [PROD_W-1:0]       d_ff, d_in, rad_ff, rad_in;
   logic [ANGLE_W-1:0]      q_ff, q_in;
   logic [36:0]             rem_ff, rem_in;
   logic [RANGE_W-1:0]      root_ff, root_in;
   logic [RANGE_W-1:0]      r_ff [3];
   logic [RANGE_W-1:0]      r_in [3];
   logic [ANGLE_W-1:0]      a_ff [2];
   logic [ANGLE_W-1:0]      a_in [2];
   eng_stat_type            stat_ff, stat_in;

   point_type               pts [3];
   logic signed [COORD_W-1:0] sens [3];
   logic [MAG_W-1:0]        off_mag [3][3];
   logic                    off_neg [3][3];
   logic [1:0]              cidx, aidx, jn;
   logic [MAG_W-1:0]        op_a, op_b;
   logic [36:0]             rem_sh, trial;
   logic [WIDE_W-1:0]       dv_cmp, num_sh;
   logic                    qbit, en_flag, ep_flag;
   logic [37:0]             ten_a0, ten_a1;

   assign pts[0]  = pa;
   assign pts[1]  = pb;
   assign pts[2]  = pc;
   assign sens[0] = sensor_x;
   assign sens[1] = sensor_y;
   assign sens[2] = sensor_z;

   always_comb begin
      for (int p = 0; p < 3; p++) begin
         {off_neg[p][0], off_mag[p][0]} = offset(pts[p].x, sens[0]);
         {off_neg[p][1], off_mag[p][1]} = offset(pts[p].y, sens[1]);
         {off_neg[p][2], off_mag[p][2]} = offset(pts[p].z, sens[2]);
      end
   end

   assign cidx = (stp_ff[1:0] == 2'd3) ? 2'd0 : stp_ff[1:0];
   assign aidx = stp_ff[1:0] - 2'd1;
   assign jn   = (j_ff == 2'd2) ? 2'd0 : j_ff + 2'd1;

   // Operand selection for the shared multiplier; its product lands in
   // prod_ff and is summed from there in the next cycle.
   always_comb begin
      op_a = mag_ff[j_ff][cidx];
      op_b = op_a;
      if (state_ff == E_DOT) begin
         op_b = mag_ff[jn][cidx];
         if (stp_ff == 6'd3) begin
            op_a = r_ff[j_ff];
            op_b = r_ff[jn];
         end
      end
   end

   assign prod_in = mul33(op_a, op_b);

   assign rem_sh = {rem_ff[34:0], rad_ff[PROD_W-1:PROD_W-2]};
   assign trial  = {2'b00, root_ff, 2'b01};
   assign dv_cmp = (stp_ff == 6'd0) ? {1'b0, d_ff, 1'b0} : {2'b00, d_ff};
   assign num_sh = (stp_ff >= 6'd2) ? {num_ff[WIDE_W-2:0], 1'b0} : num_ff;
   assign qbit   = (num_sh >= dv_cmp);

   assign ten_a0 = {1'b0, a_ff[0], 3'b000} + {3'b000, a_ff[0], 1'b0};
   assign ten_a1 = {1'b0, a_ff[1], 3'b000} + {3'b000, a_ff[1], 1'b0};
   assign en_flag = (({1'b0, r_ff[1]} + {10'd0, jump} < {1'b0, r_ff[2]}) &&
                     ({1'b0, r_ff[0]} + {10'd0, jump} < {1'b0, r_ff[2]})) ||
                    (ten_a0 < {4'd0, a_ff[1]});
   assign ep_flag = (({1'b0, r_ff[1]} + {10'd0, jump} < {1'b0, r_ff[0]}) &&
                     ({1'b0, r_ff[2]} + {10'd0, jump} < {1'b0, r_ff[0]})) ||
                    (ten_a1 < {4'd0, a_ff[0]});

   always_comb begin
      state_in     = state_ff;
      j_in         = j_ff;
      stp_in       = stp_ff + 6'd1;
      mag_in       = mag_ff;
      sgn_in       = sgn_ff;
      acc_in       = acc_ff;
      nacc_in      = nacc_ff;
      num_in       = num_ff;
      d_in         = d_ff;
      rad_in       = rad_ff;
      q_in         = q_ff;
      rem_in       = rem_ff;
      root_in      = root_ff;
      r_in         = r_ff;
      a_in         = a_ff;
      stat_in      = stat_ff;
      stat_in.done = 1'b0;
      case (state_ff)
         E_IDLE: begin
            stp_in = 6'd0;
            if (start) begin
               mag_in   = off_mag;
               sgn_in   = off_neg;
               j_in     = 2'd0;
               acc_in   = '0;
               state_in = E_SQ;
            end
         end
         E_SQ: begin
            if (stp_ff != 6'd0) acc_in = acc_ff + {2'b00, prod_ff};
            if (stp_ff == 6'd3) begin
               rad_in   = acc_in[PROD_W-1:0];
               rem_in   = '0;
               root_in  = '0;
               stp_in   = 6'd0;
               state_in = E_SQRT;
            end
         end
         E_SQRT: begin
            rad_in = {rad_ff[PROD_W-3:0], 2'b00};
            if (rem_sh >= trial) begin
               rem_in  = rem_sh - trial;
               root_in = {root_ff[RANGE_W-2:0], 1'b1};
            end else begin
               rem_in  = rem_sh;
               root_in = {root_ff[RANGE_W-2:0], 1'b0};
            end
            if (stp_ff == 6'd32) begin
               r_in[j_ff] = root_in;
               stp_in     = 6'd0;
               acc_in     = '0;
               nacc_in    = '0;
               if (j_ff == 2'd2) begin
                  j_in     = 2'd0;
                  state_in = E_DOT;
               end else begin
                  j_in     = j_ff + 2'd1;
                  state_in = E_SQ;
               end
            end
         end
         E_DOT: begin
            if (stp_ff == 6'd0 && (r_ff[j_ff] == '0 || r_ff[jn] == '0)) begin
               // A zero range has no direction: the increment saturates.
               a_in[j_ff[0]] = ANGLE_MAX;
               stp_in        = 6'd0;
               acc_in        = '0;
               nacc_in       = '0;
               if (j_ff == 2'd0) j_in = 2'd1;
               else state_in = E_FLAGS;
            end else if (stp_ff == 6'd4) begin
               d_in     = prod_ff;
               state_in = E_PREP1;
            end else if (stp_ff != 6'd0) begin
               if (sgn_ff[j_ff][aidx] != sgn_ff[jn][aidx])
                  nacc_in = nacc_ff + {2'b00, prod_ff};
               else
                  acc_in = acc_ff + {2'b00, prod_ff};
            end
         end
         E_PREP1: begin
            num_in   = {2'b00, d_ff} + nacc_ff;
            state_in = E_PREP2;
         end
         E_PREP2: begin
            if (acc_ff >= num_ff) begin
               a_in[j_ff[0]] = '0;
               stp_in        = 6'd0;
               acc_in        = '0;
               nacc_in       = '0;
               if (j_ff == 2'd0) begin
                  j_in     = 2'd1;
                  state_in = E_DOT;
               end else begin
                  state_in = E_FLAGS;
               end
            end else begin
               num_in   = num_ff - acc_ff;
               state_in = E_PREP3;
            end
         end
         E_PREP3: begin
            stp_in = 6'd0;
            q_in   = '0;
            if (num_ff >= {d_ff, 2'b00}) begin
               a_in[j_ff[0]] = ANGLE_MAX;
               acc_in        = '0;
               nacc_in       = '0;
               if (j_ff == 2'd0) begin
                  j_in     = 2'd1;
                  state_in = E_DOT;
               end else begin
                  state_in = E_FLAGS;
               end
            end else begin
               state_in = E_DIV;
            end
         end
         E_DIV: begin
            num_in = qbit ? num_sh - dv_cmp : num_sh;
            q_in   = {q_ff[ANGLE_W-2:0], qbit};
            if (stp_ff == 6'd33) begin
               a_in[j_ff[0]] = q_in;
               stp_in        = 6'd0;
               acc_in        = '0;
               nacc_in       = '0;
               if (j_ff == 2'd0) begin
                  j_in     = 2'd1;
                  state_in = E_DOT;
               end else begin
                  state_in = E_FLAGS;
               end
            end
         end
         E_FLAGS: begin
            stat_in.done      = 1'b1;
            stat_in.edge_next = en_flag;
            stat_in.edge_prev = ep_flag;
            state_in          = E_IDLE;
         end
         default: state_in = E_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= E_IDLE;
         stat_ff  <= '0;
         stp_ff   <= '0;
         j_ff     <= '0;
      end else begin
         state_ff <= state_in;
         stat_ff  <= stat_in;
         stp_ff   <= stp_in;
         j_ff     <= j_in;
      end
      mag_ff  <= mag_in;
      sgn_ff  <= sgn_in;
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
      nacc_ff <= nacc_in;
      num_ff  <= num_in;
      d_ff    <= d_in;
      rad_ff  <= rad_in;
      q_ff    <= q_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      r_ff    <= r_in;
      a_ff    <= a_in;
   end

   assign stat = stat_ff;

endmodule

### rtl/core/lidar_curvature_edge_classifier.sv
// ---------------------------------------------------------------------------
// lidar_curvature_edge_classifier: curvature and edge flags of lidar points
// Row of window cells, range and angle engine, result register.
// ---------------------------------------------------------------------------
// Points enter in ring order and shift through a row of 2*HALF_WINDOW+1
// cells. A point that leaves the window short of a full run of one ring
// and frame gives no result. A point that fills the window starts the
// classification of the window's center: three ranges (a sum of three
// squares and 33 square root steps each) and two angle increments (a dot
// product, setup and 34 divide steps each) run one after another on one
// shared multiplier, root and divider. The curvature sum runs along the
// cell row at the same time. While a result waits for rsp_tready the next
// point is accepted, but none from engine start until the result loads.
module lidar_curvature_edge_classifier #(
   parameter int HALF_WINDOW = 5,
   parameter int MAX_RINGS   = 64
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [95:0]                        req_tdata,  // px, py, pz
   input  logic [6:0]                         req_tuser,  // ring_id, frame_start
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [95:0]                        rsp_tdata,  // cx, cy, cz
   output logic [2:0]                         rsp_tuser,  // is_flat, edge_next, edge_prev
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [lcec_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [lcec_pkg::COORD_W-1:0]       csr_data
);
   import lcec_pkg::*;

   localparam int WIN    = 2 * HALF_WINDOW + 1;
   localparam int FILL_W = $clog2(WIN + 1);
   localparam int SUM_W  = COORD_W + $clog2(4 * HALF_WINDOW + 1) + 1;

   typedef enum logic [1:0] {T_IDLE, T_RUN, T_OUT} top_state_type;

   top_state_type             state_ff, state_in;
   logic [FILL_W-1:0]         fill_ff, fill_in;
   logic                      start_ff, start_in;
   logic signed [COORD_W-1:0] sx_ff, sx_in, sy_ff, sy_in, sz_ff, sz_in;
   logic [LIMIT_W-1:0]        limit_ff, limit_in;
   logic [JUMP_W-1:0]         jump_ff, jump_in;
   logic                      rv_ff, rv_in;
   logic [95:0]               rd_ff, rd_in;
   logic [2:0]                ru_ff, ru_in;

   point_type                 new_pt;
   point_type                 cell_q [WIN];
   logic signed [SUM_W-1:0]   ps_x [WIN+1];
   logic signed [SUM_W-1:0]   ps_y [WIN+1];
   logic signed [SUM_W-1:0]   ps_z [WIN+1];
   logic                      accept, store, ring_bad, load;
   logic [FILL_W-1:0]         fill0, fill1, fill2;
   eng_stat_type              eng;
   logic signed [SUM_W-1:0]   fsum [3];
   logic [SUM_W-1:0]          fmag [3];
   logic [33:0]               sqsum;
   logic                      too_big, is_flat;

   assign new_pt.x    = req_tdata[31:0];
   assign new_pt.y    = req_tdata[63:32];
   assign new_pt.z    = req_tdata[95:64];
   assign new_pt.ring = req_tuser[5:0];

   assign req_tready = (state_ff == T_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   assign ps_x[0] = '0;
   assign ps_y[0] = '0;
   assign ps_z[0] = '0;

   for (genvar i = 0; i < WIN; i++) begin : g_cell
      lcec_cell #(
         .SUM_W         (SUM_W),
         .CENTER        (i == HALF_WINDOW),
         .CENTER_WEIGHT (2 * HALF_WINDOW)
      ) u_cell (
         .clock    (clock),
         .shift_en (store),
         .d_in     ((i == WIN - 1) ? new_pt : cell_q[(i + 1) % WIN]),
         .q_out    (cell_q[i]),
         .sx_in    (ps_x[i]),
         .sy_in    (ps_y[i]),
         .sz_in    (ps_z[i]),
         .sx_out   (ps_x[i+1]),
         .sy_out   (ps_y[i+1]),
         .sz_out   (ps_z[i+1])
      );
   end

   lcec_engine u_engine (
      .clock    (clock),
      .reset    (reset),
      .start    (start_ff),
      .pa       (cell_q[HALF_WINDOW-1]),
      .pb       (cell_q[HALF_WINDOW]),
      .pc       (cell_q[HALF_WINDOW+1]),
      .sensor_x (sx_ff),
      .sensor_y (sy_ff),
      .sensor_z (sz_ff),
      .jump     (jump_ff),
      .stat     (eng)
   );

   // Curvature: the row sum has long settled when the engine finishes.
   assign fsum[0] = ps_x[WIN];
   assign fsum[1] = ps_y[WIN];
   assign fsum[2] = ps_z[WIN];
   always_comb begin
      too_big = 1'b0;
      sqsum   = '0;
      for (int c = 0; c < 3; c++) begin
         fmag[c] = fsum[c][SUM_W-1] ? $unsigned(-fsum[c]) : $unsigned(fsum[c]);
         if (fmag[c][SUM_W-1:16] != '0) too_big = 1'b1;
         sqsum = sqsum + {2'b00, {16'd0, fmag[c][15:0]} * {16'd0, fmag[c][15:0]}};
      end
      is_flat = !too_big && (sqsum < {2'b00, limit_ff});
   end

   assign ring_bad = ({3'b000, new_pt.ring} >= 9'(MAX_RINGS));
   assign fill0    = req_tuser[6] ? '0 : fill_ff;
   assign fill1    = (fill0 != '0 && cell_q[WIN-1].ring != new_pt.ring) ? '0 : fill0;
   assign fill2    = (fill1 == FILL_W'(WIN)) ? fill1 : fill1 + 1'b1;
   assign store    = accept && !ring_bad;
   assign load     = (state_ff == T_OUT) && (!rv_ff || rsp_tready);

   always_comb begin
      state_in = state_ff;
      fill_in  = fill_ff;
      start_in = 1'b0;
      if (accept) begin
         if (ring_bad) begin
            fill_in = '0;
         end else begin
            fill_in = fill2;
            if (fill2 == FILL_W'(WIN)) begin
               state_in = T_RUN;
               start_in = 1'b1;
            end
         end
      end
      if (state_ff == T_RUN && eng.done) state_in = T_OUT;
      if (load) state_in = T_IDLE;
   end

   always_comb begin
      rv_in = rv_ff;
      rd_in = rd_ff;
      ru_in = ru_ff;
      if (load) begin
         rv_in = 1'b1;
         rd_in = {cell_q[HALF_WINDOW].z, cell_q[HALF_WINDOW].y, cell_q[HALF_WINDOW].x};
         ru_in = {eng.edge_prev, eng.edge_next, is_flat};
      end else if (rsp_tready) begin
         rv_in = 1'b0;
      end
   end

   always_comb begin
      sx_in    = sx_ff;
      sy_in    = sy_ff;
      sz_in    = sz_ff;
      limit_in = limit_ff;
      jump_in  = jump_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_SENSOR_X:   sx_in    = csr_data;
            CSR_SENSOR_Y:   sy_in    = csr_data;
            CSR_SENSOR_Z:   sz_in    = csr_data;
            CSR_FLAT_LIMIT: limit_in = csr_data;
            CSR_JUMP:       jump_in  = csr_data[JUMP_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= T_IDLE;
         fill_ff  <= '0;
         start_ff <= 1'b0;
         rv_ff    <= 1'b0;
         sx_ff    <= '0;
         sy_ff    <= '0;
         sz_ff    <= '0;
         limit_ff <= FLAT_LIMIT_RESET;
         jump_ff  <= JUMP_RESET;
      end else begin
         state_ff <= state_in;
         fill_ff  <= fill_in;
         start_ff <= start_in;
         rv_ff    <= rv_in;
         sx_ff    <= sx_in;
         sy_ff    <= sy_in;
         sz_ff    <= sz_in;
         limit_ff <= limit_in;
         jump_ff  <= jump_in;
      end
      rd_ff <= rd_in;
      ru_ff <= ru_in;
   end

   assign rsp_tvalid = rv_ff;
   assign rsp_tdata  = rd_ff;
   assign rsp_tuser  = ru_ff;

endmodule

### tb/tb_lidar_curvature_edge_classifier.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_lidar_curvature_edge_classifier: self-checking bench of the classifier
// Streams runs of lidar points under random gaps and stalls, predicts each
// classified point and compares every result beat field by field.
// ---------------------------------------------------------------------------
module tb_lidar_curvature_edge_classifier;
   import lcec_pkg::*;

   localparam int HALF = 5;
   localparam int WIN  = 2 * HALF + 1;
   localparam int SETTLE = 400;

   typedef struct {
      point_type pt;
      bit        frame_start;
   } point_beat_type;

   typedef struct {
      logic [31:0] x, y, z;
      bit          flat, edge_next, edge_prev;
   } classified_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [95:0] req_tdata = '0;
   logic [6:0]  req_tuser = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [95:0] rsp_tdata;
   logic [2:0]  rsp_tuser;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [COORD_W-1:0]   csr_data = '0;

   lidar_curvature_edge_classifier uut (.*);

   // Predictor state: configuration and point window.
   logic signed [31:0] org_x = 0, org_y = 0, org_z = 0;
   logic [31:0] flat_lim = FLAT_LIMIT_RESET;
   logic [23:0] jump_dist = JUMP_RESET;
   point_type   pts [WIN];
   int          fill = 0;

   point_beat_type pending_points[$];
   classified_type expected_points[$];
   point_beat_type on_bus;
   int  errors = 0;
   bit  no_idle = 0;
   bit  hold_rsp = 0;
   int  phase = 0;

   initial begin
      forever #6 clock = ~clock;
   end

   task automatic report(string what);
      $display("mismatch at %0t: %s", $time, what);
      errors++;
   endtask

   function automatic logic [32:0] range_of(point_type p);
      logic [127:0] s, m, t;
      logic [32:0]  r;
      m = (p.x - longint'(org_x)) < 0 ? -(p.x - longint'(org_x)) : (p.x - longint'(org_x));
      s = m * m;
      m = (p.y - longint'(org_y)) < 0 ? -(p.y - longint'(org_y)) : (p.y - longint'(org_y));
      s += m * m;
      m = (p.z - longint'(org_z)) < 0 ? -(p.z - longint'(org_z)) : (p.z - longint'(org_z));
      s += m * m;
      r = '0;
      for (int b = 32; b >= 0; b--) begin
         t = {95'd0, r | (33'd1 << b)};
         if (s >= t * t) r = r | (33'd1 << b);
      end
      return r;
   endfunction

   // One minus cosine between two sensor rays, Q2.32, saturating.
   function automatic logic [33:0] angle_step(point_type p, point_type q,
                                              logic [32:0] ra, logic [32:0] rb);
      logic signed [127:0] dot, num, den;
      logic [127:0] quo;
      if (ra == 0 || rb == 0) return ANGLE_MAX;
      dot = 128'(signed'(p.x - longint'(org_x))) * 128'(signed'(q.x - longint'(org_x)))
          + 128'(signed'(p.y - longint'(org_y))) * 128'(signed'(q.y - longint'(org_y)))
          + 128'(signed'(p.z - longint'(org_z))) * 128'(signed'(q.z - longint'(org_z)));
      den = $signed({95'd0, ra}) * $signed({95'd0, rb});
      num = den - dot;
      if (num <= 0) return '0;
      if (num >= 4 * den) return ANGLE_MAX;
      quo = (num <<< 32) / den;
      return quo[33:0];
   endfunction

   function automatic bit is_flat_window();
      longint df [3];
      longint m;
      longint unsigned sum;
      df = '{0, 0, 0};
      sum = 0;
      for (int i = 0; i < WIN; i++) begin
         longint k;
         k = (i == HALF) ? -2 * HALF : 1;
         df[0] += k * pts[i].x;
         df[1] += k * pts[i].y;
         df[2] += k * pts[i].z;
      end
      for (int c = 0; c < 3; c++) begin
         m = df[c] < 0 ? -df[c] : df[c];
         if (m >= 65536) return 0;
         sum += m * m;
      end
      return sum < {32'd0, flat_lim};
   endfunction

   task automatic classify(point_beat_type b);
      logic [32:0] r0, r1, r2;
      logic [63:0] a0, a1, j;
      classified_type e;
      if (b.frame_start) fill = 0;
      if (fill > 0 && pts[WIN-1].ring != b.pt.ring) fill = 0;
      for (int i = 0; i < WIN - 1; i++) pts[i] = pts[i+1];
      pts[WIN-1] = b.pt;
      if (fill < WIN) fill++;
      if (fill < WIN) return;
      r0 = range_of(pts[HALF-1]);
      r1 = range_of(pts[HALF]);
      r2 = range_of(pts[HALF+1]);
      a0 = angle_step(pts[HALF-1], pts[HALF], r0, r1);
      a1 = angle_step(pts[HALF], pts[HALF+1], r1, r2);
      j = jump_dist;
      e.x = pts[HALF].x;
      e.y = pts[HALF].y;
      e.z = pts[HALF].z;
      e.flat = is_flat_window();
      e.edge_next = (r1 + j < r2 && r0 + j < r2) || 10 * a0 < a1;
      e.edge_prev = (r1 + j < r0 && r2 + j < r0) || 10 * a1 < a0;
      expected_points = {expected_points, e};
   endtask

   // Sender: one beat in flight, refilled from the pending queue.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) classify(on_bus);
         if (!req_tvalid || req_tready) begin
            if (pending_points.size() > 0 && (no_idle || $urandom_range(99) >= 34)) begin
               on_bus = pending_points.pop_front();
               req_tvalid <= 1'b1;
               req_tdata <= {on_bus.pt.z, on_bus.pt.y, on_bus.pt.x};
               req_tuser <= {on_bus.frame_start, on_bus.pt.ring};
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Receiver and checker.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_points.size() == 0) begin
               report($sformatf("unexpected result beat %h", rsp_tdata));
            end else begin
               classified_type e;
               e = expected_points.pop_front();
               if (rsp_tdata[31:0] != e.x)
                  report($sformatf("cx %h expected %h", rsp_tdata[31:0], e.x));
               if (rsp_tdata[63:32] != e.y)
                  report($sformatf("cy %h expected %h", rsp_tdata[63:32], e.y));
               if (rsp_tdata[95:64] != e.z)
                  report($sformatf("cz %h expected %h", rsp_tdata[95:64], e.z));
               if (rsp_tuser[0] != e.flat)
                  report($sformatf("is_flat %b expected %b", rsp_tuser[0], e.flat));
               if (rsp_tuser[1] != e.edge_next)
                  report($sformatf("edge_next %b expected %b", rsp_tuser[1], e.edge_next));
               if (rsp_tuser[2] != e.edge_prev)
                  report($sformatf("edge_prev %b expected %b", rsp_tuser[2], e.edge_prev));
            end
         end
         rsp_tready <= !hold_rsp && (no_idle || $urandom_range(99) >= 34);
      end
   end

   // A long receiver stall so that the result register fills and input stalls.
   initial begin
      wait (phase == 2);
      hold_rsp = 1'b1;
      repeat (1500) @(posedge clock);
      hold_rsp = 1'b0;
   end

   task automatic csr_write(csr_idx_type idx, logic [31:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         CSR_SENSOR_X:   org_x = value;
         CSR_SENSOR_Y:   org_y = value;
         CSR_SENSOR_Z:   org_z = value;
         CSR_FLAT_LIMIT: flat_lim = value;
         CSR_JUMP:       jump_dist = value[23:0];
         default: ;
      endcase
   endtask

   task automatic configure(logic [31:0] sx, logic [31:0] sy, logic [31:0] sz,
                            logic [31:0] lim, logic [23:0] jmp);
      csr_write(CSR_SENSOR_X, sx);
      csr_write(CSR_SENSOR_Y, sy);
      csr_write(CSR_SENSOR_Z, sz);
      csr_write(CSR_FLAT_LIMIT, lim);
      csr_write(CSR_JUMP, {8'd0, jmp});
   endtask

   task automatic drain();
      while (!(pending_points.size() == 0 && !req_tvalid && expected_points.size() == 0))
         @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic add_point(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                            logic [5:0] ring, bit fs);
      point_beat_type b;
      b.pt.x = x;
      b.pt.y = y;
      b.pt.z = z;
      b.pt.ring = ring;
      b.frame_start = fs;
      pending_points = {pending_points, b};
   endtask

   // A scan run along one ring: a near-straight line with small jitter,
   // occasional occlusion jumps, rays through the origin and wild points.
   task automatic add_scan_run(int len, bit fs);
      logic [5:0]  ring;
      logic signed [31:0] bx, by, bz, st;
      logic [31:0] x, y, z;
      int jit;
      ring = $urandom_range(63);
      bx = $signed($urandom_range(33554431)) - 32'sd16777216;
      by = $signed($urandom_range(33554431)) - 32'sd16777216;
      bz = $signed($urandom_range(4194303)) - 32'sd2097152;
      st = $signed($urandom_range(8191)) - 32'sd4096;
      jit = $urandom_range(3) == 0 ? 4000 : 3;
      for (int i = 0; i < len; i++) begin
         if ($urandom_range(19) == 0) bx += $signed($urandom_range(2097151)) - 32'sd1048576;
         x = bx + $signed($urandom_range(2 * jit)) - jit;
         y = by + st * i + $signed($urandom_range(2 * jit)) - jit;
         z = bz;
         case ($urandom_range(39))
            0: begin x = $urandom; y = $urandom; z = $urandom; end
            1: begin x = org_x; y = org_y; z = org_z; end
            default: ;
         endcase
         add_point(x, y, z, ring, fs && i == 0);
      end
   endtask

   task automatic add_random(int count);
      int n;
      n = 0;
      while (n < count) begin
         int len;
         if ($urandom_range(4) == 0) len = $urandom_range(10, 1);
         else len = $urandom_range(30, 11);
         add_scan_run(len, $urandom_range(3) == 0);
         n += len;
      end
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed: full-scale alternating coordinates on the top ring, a new
      // frame mid-run, a window of points at the sensor origin (zero range),
      // and a ring change.
      for (int i = 0; i < 11; i++) begin
         if (i % 2 == 0) add_point(32'h7fffffff, 32'h80000000, 32'h7fffffff, 6'd63, 0);
         else add_point(32'h80000000, 32'h7fffffff, 32'h80000000, 6'd63, 0);
      end
      add_point(32'h80000000, 32'h80000000, 32'h80000000, 6'd63, 0);
      add_point(32'h0, 32'h0, 32'h0, 6'd0, 1);
      for (int i = 0; i < 10; i++) add_point(32'h0, 32'h0, 32'h0, 6'd0, 0);
      add_point(32'h00010000, 32'h0, 32'h0, 6'd1, 0);
      drain();

      phase = 1;
      configure($urandom, $urandom, $urandom, 32'hffffffff, 24'd0);
      add_random(170);
      drain();

      phase = 2;
      configure(32'h80000000, 32'h7fffffff, 32'h0, 32'h0, 24'hffffff);
      add_random(170);
      drain();

      // The sender pauses halfway until every result is back.
      phase = 3;
      configure($urandom, $urandom, $urandom, $urandom, 24'($urandom));
      add_random(85);
      drain();
      add_random(85);
      drain();

      phase = 4;
      no_idle = 1;
      configure(32'h0, 32'h0, 32'h0, FLAT_LIMIT_RESET, JUMP_RESET);
      add_random(170);
      drain();
      no_idle = 0;

      phase = 5;
      configure(32'h7fffffff, $urandom, 32'h80000000, $urandom_range(65535), 24'($urandom));
      add_random(170);
      drain();

      if (errors == 0) $display("*** PASSED ***");
      else $display("*** FAILED ***");
      $finish;
   end

   initial begin
      #12_000_000;
      $display("*** FAILED ***");
      $finish;
   end

endmodule
